### rtl/core/spqm_pkg.sv
package spqm_pkg;

    // transaction field widths
    localparam int KIND_W = 2;
    localparam int LIST_W = 6;
    localparam int KEY_W  = 27;

    // s_tdata: list_id, member_id; padded to whole bytes
    localparam int S_TDATA_W = 40;
    // m_tdata: found, pool_full; padded to whole bytes
    localparam int M_TDATA_W = 8;

    // operation codes carried in s_tuser
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

endpackage

### rtl/core/spqm_ram.sv
module spqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/shared_pool_multi_queue_manager.sv
// Sequence: append goes through ST_A_RD, then ST_A_LINK unless the list was empty; query
//   and remove walk the list in ST_W_QRD and ST_W_NODE, and remove adds ST_R_FREE when it
//   unlinks; a full pool, a bad list or kind 3 goes straight to ST_RESP.
// Throughput: one transaction at a time, held while m_tready is low; one node per cycle in the walk.
// Reset: rst_n is asynchronous, active low. After reset a clearing pass sets links and
//   list heads; s_tready stays low.
module shared_pool_multi_queue_manager #(
    parameter int POOL_NODES = 256,
    parameter int NUM_QUEUES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input transactions
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spqm_pkg::S_TDATA_W-1:0] s_tdata,  // [5:0] list_id, [32:6] member_id
    input  logic [spqm_pkg::KIND_W-1:0]   s_tuser,  // [1:0] kind
    // result transactions
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spqm_pkg::M_TDATA_W-1:0] m_tdata   // [0] found, [1] pool_full
);

    localparam int KEY_W  = spqm_pkg::KEY_W;
    localparam int LIST_W = spqm_pkg::LIST_W;
    // pointers carry one extra code (POOL_NODES) meaning end of list
    localparam int PTR_W  = $clog2(POOL_NODES + 1);
    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int QA_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CLR_N  = (POOL_NODES > NUM_QUEUES) ? POOL_NODES : NUM_QUEUES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int NODE_W = KEY_W + PTR_W;   // {member, next}
    localparam int QW_W   = PTR_W + IDX_W;   // {head, tail}

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    // sequencer states
    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_A_RD   = 4'd2;  // free node and list entry ready
    localparam logic [3:0] ST_A_LINK = 4'd3;  // old tail ready, link new node
    localparam logic [3:0] ST_W_QRD  = 4'd4;  // list entry ready, start walk
    localparam logic [3:0] ST_W_NODE = 4'd5;  // one node per cycle
    localparam logic [3:0] ST_R_FREE = 4'd6;  // push removed node on free list
    localparam logic [3:0] ST_RESP   = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [PTR_W-1:0]  free_head_reg, free_head_next;
    logic [spqm_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [LIST_W-1:0] list_reg, list_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  prev_reg, prev_next;
    logic [KEY_W-1:0]  prev_mem_reg, prev_mem_next;
    logic [KEY_W-1:0]  cur_mem_reg, cur_mem_next;
    logic [PTR_W-1:0]  steps_reg, steps_next;
    logic              found_reg, found_next;
    logic              full_reg, full_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_data_reg, m_data_next;   // {pool_full, found}

    // node RAM
    logic              n_we;
    logic [IDX_W-1:0]  n_waddr, n_raddr;
    logic [NODE_W-1:0] n_wdata, n_rdata;
    logic [KEY_W-1:0]  n_rd_member;
    logic [PTR_W-1:0]  n_rd_next;

    // list RAM
    logic              q_we;
    logic [QA_W-1:0]   q_waddr, q_raddr;
    logic [QW_W-1:0]   q_wdata, q_rdata;
    logic [PTR_W-1:0]  q_rd_head;
    logic [IDX_W-1:0]  q_rd_tail;

    logic [LIST_W-1:0] in_list;
    logic [KEY_W-1:0]  in_key;
    logic              in_ok;
    logic [PTR_W-1:0]  steps_inc;

    assign n_rd_member = n_rdata[NODE_W-1:PTR_W];
    assign n_rd_next   = n_rdata[PTR_W-1:0];
    assign q_rd_head   = q_rdata[QW_W-1:IDX_W];
    assign q_rd_tail   = q_rdata[IDX_W-1:0];

    assign in_list   = s_tdata[LIST_W-1:0];
    assign in_key    = s_tdata[LIST_W+KEY_W-1:LIST_W];
    assign in_ok     = 32'(in_list) < 32'(NUM_QUEUES);
    assign steps_inc = steps_reg + PTR_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(spqm_pkg::M_TDATA_W-2){1'b0}}, m_data_reg};

    spqm_ram #(
        .WIDTH(NODE_W),
        .DEPTH(POOL_NODES)
    ) u_node_ram (
        .clk  (clk),
        .we   (n_we),
        .waddr(n_waddr),
        .wdata(n_wdata),
        .raddr(n_raddr),
        .rdata(n_rdata)
    );

    spqm_ram #(
        .WIDTH(QW_W),
        .DEPTH(NUM_QUEUES)
    ) u_list_ram (
        .clk  (clk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        kind_next      = kind_reg;
        list_next      = list_reg;
        key_next       = key_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_mem_next  = prev_mem_reg;
        cur_mem_next   = cur_mem_reg;
        steps_next     = steps_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        n_we    = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        n_raddr = '0;
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // free chain i -> i+1, every list empty
                if ((CLR_W + 1)'(clr_reg) < (CLR_W + 1)'(POOL_NODES))
                begin
                    n_we    = 1'b1;
                    n_waddr = IDX_W'(clr_reg);
                    n_wdata = {{KEY_W{1'b0}}, PTR_W'(clr_reg) + PTR_W'(1)};
                end
                if ((CLR_W + 1)'(clr_reg) < (CLR_W + 1)'(NUM_QUEUES))
                begin
                    q_we    = 1'b1;
                    q_waddr = QA_W'(clr_reg);
                    q_wdata = {NIL, {IDX_W{1'b0}}};
                end
                if ((CLR_W + 1)'(clr_reg) == (CLR_W + 1)'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end

            ST_IDLE:
            begin
                n_raddr = IDX_W'(free_head_reg);
                q_raddr = QA_W'(in_list);
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    list_next  = in_list;
                    key_next   = in_key;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_RESP;
                    if (in_ok)
                    begin
                        case (s_tuser)
                            spqm_pkg::KIND_APPEND:
                            begin
                                if (free_head_reg == NIL)
                                begin
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_A_RD;
                                end
                            end
                            spqm_pkg::KIND_QUERY,
                            spqm_pkg::KIND_REMOVE:
                            begin
                                state_next = ST_W_QRD;
                            end
                            default:
                            begin
                                state_next = ST_RESP;
                            end
                        endcase
                    end
                end
            end

            ST_A_RD:
            begin
                // new node = free head, gets key and end-of-list link
                n_we           = 1'b1;
                n_waddr        = IDX_W'(free_head_reg);
                n_wdata        = {key_reg, NIL};
                free_head_next = n_rd_next;
                cur_next       = free_head_reg;
                q_we           = 1'b1;
                q_waddr        = QA_W'(list_reg);
                if (q_rd_head == NIL)
                begin
                    q_wdata    = {free_head_reg, IDX_W'(free_head_reg)};
                    state_next = ST_RESP;
                end
                else
                begin
                    q_wdata    = {q_rd_head, IDX_W'(free_head_reg)};
                    n_raddr    = q_rd_tail;
                    tail_next  = q_rd_tail;
                    state_next = ST_A_LINK;
                end
            end

            ST_A_LINK:
            begin
                n_we       = 1'b1;
                n_waddr    = tail_reg;
                n_wdata    = {n_rd_member, cur_reg};
                state_next = ST_RESP;
            end

            ST_W_QRD:
            begin
                head_next = q_rd_head;
                tail_next = q_rd_tail;
                if (q_rd_head == NIL)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    n_raddr    = IDX_W'(q_rd_head);
                    cur_next   = q_rd_head;
                    prev_next  = NIL;
                    steps_next = '0;
                    state_next = ST_W_NODE;
                end
            end

            ST_W_NODE:
            begin
                if (n_rd_member == key_reg)
                begin
                    found_next = 1'b1;
                    if (kind_reg == spqm_pkg::KIND_QUERY)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        // unlink cur; the free-list push follows next cycle
                        q_waddr      = QA_W'(list_reg);
                        cur_mem_next = n_rd_member;
                        if (prev_reg == NIL)
                        begin
                            q_we    = 1'b1;
                            q_wdata = {n_rd_next, tail_reg};
                        end
                        else
                        begin
                            n_we    = 1'b1;
                            n_waddr = IDX_W'(prev_reg);
                            n_wdata = {prev_mem_reg, n_rd_next};
                            if (tail_reg == IDX_W'(cur_reg))
                            begin
                                q_we    = 1'b1;
                                q_wdata = {head_reg, IDX_W'(prev_reg)};
                            end
                        end
                        state_next = ST_R_FREE;
                    end
                end
                else if (n_rd_next == NIL || steps_inc == PTR_W'(POOL_NODES))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    n_raddr       = IDX_W'(n_rd_next);
                    cur_next      = n_rd_next;
                    prev_next     = cur_reg;
                    prev_mem_next = n_rd_member;
                    steps_next    = steps_inc;
                end
            end

            ST_R_FREE:
            begin
                n_we           = 1'b1;
                n_waddr        = IDX_W'(cur_reg);
                n_wdata        = {cur_mem_reg, free_head_reg};
                free_head_next = cur_reg;
                state_next     = ST_RESP;
            end

            ST_RESP:
            begin
                // output register frees up when empty or being drained
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {full_reg, found_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        list_reg     <= list_next;
        key_reg      <= key_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_mem_reg <= prev_mem_next;
        cur_mem_reg  <= cur_mem_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        full_reg     <= full_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### tb/sv/tb_shared_pool_multi_queue_manager.sv
module tb_shared_pool_multi_queue_manager;

    localparam int KIND_W    = spqm_pkg::KIND_W;
    localparam int LIST_W    = spqm_pkg::LIST_W;
    localparam int KEY_W     = spqm_pkg::KEY_W;
    localparam int S_TDATA_W = spqm_pkg::S_TDATA_W;
    localparam int M_TDATA_W = spqm_pkg::M_TDATA_W;

    localparam logic [KIND_W-1:0] KIND_APPEND = spqm_pkg::KIND_APPEND;
    localparam logic [KIND_W-1:0] KIND_QUERY  = spqm_pkg::KIND_QUERY;
    localparam logic [KIND_W-1:0] KIND_REMOVE = spqm_pkg::KIND_REMOVE;

    localparam int POOL_NODES   = 256;
    localparam int NUM_QUEUES   = 64;
    localparam int NIL          = POOL_NODES;      // end-of-chain / empty marker
    localparam int LIMIT_CYCLES = 2000000;
    localparam int TAIL_CYCLES  = POOL_NODES + 20; // longest walk plus slack

    // kind 3 has no operation behind it; the block must answer all zeros
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MAX   = 27'd99999999;
    localparam logic [KEY_W-1:0] KEY_ALT_A = 27'h5555555;
    localparam logic [KEY_W-1:0] KEY_ALT_B = 27'h2AAAAAA;

    // one expected answer, with the transaction that caused it for messages
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [LIST_W-1:0] list_id;
        logic [KEY_W-1:0]  member_id;
        logic              found;
        logic              pool_full;
    } answer_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int cycles         = 0;
    int n_ops[4]       = '{default: 0};
    int n_hits         = 0;
    int n_full         = 0;

    // shadow of the node pool and the list heads/tails
    logic [KEY_W-1:0] node_key   [POOL_NODES];
    int               node_link  [POOL_NODES];
    int               free_top;
    int               list_first [NUM_QUEUES];
    int               list_last  [NUM_QUEUES];

    answer_t pending_answers[$];

    shared_pool_multi_queue_manager #(
        .POOL_NODES (POOL_NODES),
        .NUM_QUEUES (NUM_QUEUES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles, %0d answers outstanding",
                     $time, cycles, pending_answers.size());
            $display("shared_pool_multi_queue_manager verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge clk)
    begin : check_result
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found=%0b pool_full=%0b",
                         $time, m_tdata[0], m_tdata[1]);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want.found)
                begin
                    errors++;
                    $display("%0t: found mismatch (kind %0d list %0d key %0d) expected %0b actual %0b",
                             $time, want.kind, want.list_id, want.member_id, want.found,
                             m_tdata[0]);
                end
                if (m_tdata[1] !== want.pool_full)
                begin
                    errors++;
                    $display("%0t: pool_full mismatch (kind %0d list %0d key %0d) expected %0b actual %0b",
                             $time, want.kind, want.list_id, want.member_id, want.pool_full,
                             m_tdata[1]);
                end
            end
        end
    end

    function automatic void pool_reset();
        for (int i = 0; i < POOL_NODES; i++)
        begin
            node_key[i]  = '0;
            node_link[i] = i + 1;
        end
        free_top = 0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            list_first[q] = NIL;
            list_last[q]  = 0;
        end
    endfunction

    // returns 1 when the pool is exhausted and nothing was stored
    function automatic bit pool_append(input int q, input logic [KEY_W-1:0] key);
        int n;
        n = free_top;
        if (n >= NIL)
            return 1'b1;
        free_top     = node_link[n];
        node_key[n]  = key;
        node_link[n] = NIL;
        if (list_first[q] >= NIL)
            list_first[q] = n;
        else
            node_link[list_last[q]] = n;
        list_last[q] = n;
        return 1'b0;
    endfunction

    function automatic bit list_holds(input int q, input logic [KEY_W-1:0] key);
        int cur;
        cur = list_first[q];
        for (int steps = 0; steps < POOL_NODES && cur < NIL; steps++)
        begin
            if (node_key[cur] == key)
                return 1'b1;
            cur = node_link[cur];
        end
        return 1'b0;
    endfunction

    // unlinks the first node holding key and pushes it on the free chain
    function automatic bit list_unlink(input int q, input logic [KEY_W-1:0] key);
        int cur;
        int prev;
        int nxt;
        cur  = list_first[q];
        prev = NIL;
        for (int steps = 0; steps < POOL_NODES && cur < NIL; steps++)
        begin
            if (node_key[cur] == key)
            begin
                nxt = node_link[cur];
                if (prev >= NIL)
                    list_first[q] = nxt;
                else
                    node_link[prev] = nxt;
                if (list_last[q] == cur && prev < NIL)
                    list_last[q] = prev;
                node_link[cur] = free_top;
                free_top       = cur;
                return 1'b1;
            end
            prev = cur;
            cur  = node_link[cur];
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(input logic [KIND_W-1:0] kind,
                                               input logic [LIST_W-1:0] lid,
                                               input logic [KEY_W-1:0]  key);
        answer_t a;
        a.kind      = kind;
        a.list_id   = lid;
        a.member_id = key;
        a.found     = 1'b0;
        a.pool_full = 1'b0;
        if (int'(lid) < NUM_QUEUES)
        begin
            case (kind)
                KIND_APPEND: a.pool_full = pool_append(int'(lid), key);
                KIND_QUERY:  a.found     = list_holds(int'(lid), key);
                KIND_REMOVE: a.found     = list_unlink(int'(lid), key);
                default:     ;
            endcase
        end
        return a;
    endfunction

    function automatic int list_len(input int q);
        int cur;
        int len;
        cur = list_first[q];
        len = 0;
        while (cur < NIL && len < POOL_NODES)
        begin
            len++;
            cur = node_link[cur];
        end
        return len;
    endfunction

    // skewed toward a few small keys so duplicates and hits are common
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return KEY_MAX;
            2, 3, 4, 5: return KEY_W'($urandom_range(0, 15));
            default:    return KEY_W'($urandom_range(0, KEY_MAX));
        endcase
    endfunction

    // key of a random node currently in list q, or a random key if empty
    function automatic logic [KEY_W-1:0] listed_key(input int q);
        int len;
        int cur;
        len = list_len(q);
        if (len == 0)
            return rand_key();
        cur = list_first[q];
        repeat ($urandom_range(0, len - 1))
            cur = node_link[cur];
        return node_key[cur];
    endfunction

    // one input transaction; the shadow pool is updated at acceptance
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic [LIST_W-1:0] lid,
                           input logic [KEY_W-1:0]  key);
        answer_t a;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - LIST_W - KEY_W){1'b0}}, key, lid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = predict_answer(kind, lid, key);
        pending_answers.push_back(a);
        n_ops[kind]++;
        n_hits += a.found;
        n_full += a.pool_full;
    endtask

    // sender holds off until every outstanding answer is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(KIND_QUERY,  6'd0,  '0);          // empty list
        send_op(KIND_REMOVE, 6'd63, KEY_MAX);     // remove from empty list
        send_op(KIND_APPEND, 6'd0,  '0);
        send_op(KIND_APPEND, 6'd63, KEY_MAX);
        send_op(KIND_APPEND, 6'd0,  KEY_MAX);
        send_op(KIND_APPEND, 6'd0,  '0);          // duplicate key in the same list
        send_op(KIND_QUERY,  6'd0,  KEY_MAX);
        send_op(KIND_QUERY,  6'd63, '0);
        send_op(KIND_REMOVE, 6'd0,  '0);          // first copy, at the head
        send_op(KIND_QUERY,  6'd0,  '0);          // second copy still queued
        send_op(KIND_REMOVE, 6'd0,  '0);          // now the tail
        send_op(KIND_QUERY,  6'd0,  '0);
        send_op(KIND_REMOVE, 6'd63, KEY_MAX);     // only element of its list
        send_op(KIND_QUERY,  6'd63, KEY_MAX);
        send_op(KIND_APPEND, 6'd63, KEY_ALT_A);   // takes the node just freed
        send_op(KIND_APPEND, 6'd42, KEY_ALT_B);
        send_op(KIND_APPEND, 6'd21, KEY_ALT_A);
        send_op(KIND_REMOVE, 6'd42, KEY_ALT_A);   // key not in list
        send_op(KIND_UNUSED, 6'd21, KEY_ALT_A);   // must leave list 21 alone
        send_op(KIND_QUERY,  6'd21, KEY_ALT_A);
        send_op(KIND_APPEND, 6'd0,  KEY_ALT_B);   // list 0: MAX, ALT_B, ALT_A
        send_op(KIND_APPEND, 6'd0,  KEY_ALT_A);
        send_op(KIND_REMOVE, 6'd0,  KEY_ALT_B);   // middle node
        send_op(KIND_QUERY,  6'd0,  KEY_ALT_A);
        wait_results();
    endtask

    // fill the pool, mostly into one list so walks get long, then drain part of it
    task automatic test_pool_exhaust();
        int q;
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        while (free_top < NIL)
            send_op(KIND_APPEND, ($urandom_range(0, 6) != 0) ? 6'd7 : LIST_W'($urandom_range(0, 63)),
                    rand_key());
        repeat (6)
            send_op(KIND_APPEND, LIST_W'($urandom_range(0, 63)), rand_key());
        wait_results();
        send_op(KIND_QUERY,  6'd7, node_key[list_last[7]]);
        send_op(KIND_QUERY,  6'd7, KEY_MAX - 27'd1);
        send_op(KIND_REMOVE, 6'd7, node_key[list_last[7]]);
        send_op(KIND_APPEND, 6'd7, KEY_ALT_B);
        send_op(KIND_APPEND, 6'd7, KEY_ALT_A);    // pool full again
        repeat (130)
        begin
            if ($urandom_range(0, 1) == 0 && list_len(7) != 0)
                q = 7;
            else
            begin
                q = $urandom_range(0, NUM_QUEUES - 1);
                while (list_len(q) == 0)
                    q = $urandom_range(0, NUM_QUEUES - 1);
            end
            send_op(KIND_REMOVE, LIST_W'(q), listed_key(q));
        end
        wait_results();
    endtask

    // mixed traffic, concentrated on a few lists so they grow long
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int                r;
        int                q;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            q = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3)
                                            : $urandom_range(0, NUM_QUEUES - 1);
            if (r < 38)
            begin
                kind = KIND_APPEND;
                key  = rand_key();
            end
            else if (r < 64)
            begin
                kind = KIND_QUERY;
                key  = ($urandom_range(0, 9) < 7) ? listed_key(q) : rand_key();
            end
            else if (r < 95)
            begin
                kind = KIND_REMOVE;
                key  = ($urandom_range(0, 9) < 7) ? listed_key(q) : rand_key();
            end
            else
            begin
                kind = KIND_UNUSED;
                key  = rand_key();
            end
            send_op(kind, LIST_W'(q), key);
        end
        wait_results();
    endtask

    initial
    begin
        pool_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_exhaust();
        test_random_phase(0,  0,  170);
        test_random_phase(51, 0,  170);
        test_random_phase(0,  51, 170);
        test_random_phase(27, 27, 170);

        // anything arriving now is unexpected and gets flagged by the checker
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d appends, %0d queries, %0d removes, %0d unused-kind transactions",
                 n_ops[KIND_APPEND], n_ops[KIND_QUERY], n_ops[KIND_REMOVE], n_ops[KIND_UNUSED]);
        $display("Key hits %0d, appends refused on a full pool %0d, in %0d cycles",
                 n_hits, n_full, cycles);
        if (errors == 0)
            $display("shared_pool_multi_queue_manager verification clean");
        else
            $display("shared_pool_multi_queue_manager verification failed");
        $finish;
    end

endmodule
